// ===== hdl/asl_pkg.sv =====
// Shared types, constants and helper functions of the sprite line compositor.
`timescale 1ns / 1ps

package asl_pkg;

  localparam int NUM_PIXELS_DEFAULT = 256;
  localparam int QUEUE_DEPTH        = 4;
  localparam int PIXEL_W            = 24;
  localparam int CURSOR_W           = 18;

  localparam logic [1:0] FUNC_DRAW   = 2'd0;
  localparam logic [1:0] FUNC_FILL   = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [CURSOR_W-1:0] CURSOR_MAX = 18'sd131071;

  // One queued word, already classified and pre-scaled by the front.
  typedef struct packed {
    logic [1:0]                   func;
    logic                         first;
    logic signed [CURSOR_W-1:0]   load;
    logic [7:0]                   reps;
    logic                         wrap;
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
    logic [7:0]                   read_index;
    logic [7:0]                   fill_level;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic init_busy;
  } bk_stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_DRAW_WR,
    ST_READ,
    ST_READ_DATA,
    ST_FILL
  } back_state_t;

  // Address bits for a store of n entries; at least one bit.
  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] old_v, input logic [7:0] add_v);
    logic [8:0] sum;
    sum = {1'b0, old_v} + {1'b0, add_v};
    return sum[8] ? 8'hFF : sum[7:0];
  endfunction

endpackage

// ===== hdl/asl_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module asl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [asl_pkg::addr_bits(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [asl_pkg::addr_bits(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                       rdata
);
  import asl_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/asl_queue.sv =====
// Short flip-flop FIFO that decouples the front from the back.
`timescale 1ns / 1ps

module asl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output asl_pkg::q_stat_t     stat
);
  import asl_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (PW+1)'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

// ===== hdl/asl_front.sv =====
// Front end: accepts words, holds the brightness register, computes cursor loads.
`timescale 1ns / 1ps

module asl_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic                 in_first_pixel,
  input  logic signed [31:0]   in_sprite_position,
  input  logic signed [15:0]   in_spread_step,
  input  logic [7:0]           in_repeat_count,
  input  logic                 in_wrap_enable,
  input  logic [7:0]           in_sprite_red,
  input  logic [7:0]           in_sprite_green,
  input  logic [7:0]           in_sprite_blue,
  input  logic [7:0]           in_read_index,
  input  logic [7:0]           in_fill_level,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_brightness_shift,
  input  asl_pkg::q_stat_t     q_stat,
  input  asl_pkg::bk_stat_t    bk_stat,
  output logic                 push,
  output asl_pkg::entry_t      entry
);
  import asl_pkg::*;

  logic [2:0]         shift_r;
  logic signed [31:0] spread_off;
  logic signed [32:0] pos_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_valid) begin
      shift_r <= cfg_brightness_shift;
    end
  end

  // spread_step * 2^(16 - shift), kept at full width so nothing overflows.
  assign spread_off = $signed({in_spread_step, 16'h0000}) >>> shift_r;
  assign pos_sum    = {in_sprite_position[31], in_sprite_position}
                    + {spread_off[31], spread_off};

  assign in_ready = !q_stat.full && !bk_stat.init_busy;
  assign push     = in_valid && in_ready && (in_func != FUNC_UNUSED);

  always_comb begin
    entry.func       = in_func;
    entry.first      = in_first_pixel;
    entry.load       = {pos_sum[32], pos_sum[32:16]};
    entry.reps       = in_repeat_count;
    entry.wrap       = in_wrap_enable;
    entry.red        = in_sprite_red >> shift_r;
    entry.green      = in_sprite_green >> shift_r;
    entry.blue       = in_sprite_blue >> shift_r;
    entry.read_index = in_read_index;
    entry.fill_level = in_fill_level;
  end

endmodule

// ===== hdl/asl_back.sv =====
// Back end: sequencer that owns the frame store and carries out queued words.
`timescale 1ns / 1ps

module asl_back #(
  parameter int NUM_PIXELS = asl_pkg::NUM_PIXELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  asl_pkg::entry_t      q_entry,
  input  asl_pkg::q_stat_t     q_stat,
  output logic                 q_pop,
  output asl_pkg::bk_stat_t    bk_stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_red,
  output logic [7:0]           out_read_green,
  output logic [7:0]           out_read_blue
);
  import asl_pkg::*;

  localparam int AW = addr_bits(NUM_PIXELS);

  back_state_t                 state_r, state_nxt;
  entry_t                      item_r, item_nxt;
  logic signed [CURSOR_W-1:0]  cursor_r, cursor_nxt;
  logic [7:0]                  pass_r, pass_nxt;
  logic [AW-1:0]               sweep_r, sweep_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0]          out_pix_r, out_pix_nxt;

  logic                        ram_we, ram_re, out_load;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [PIXEL_W-1:0]          ram_wdata, ram_rdata;

  logic                        in_strip, sweep_last, rd_ok, step_cursor;
  logic [AW-1:0]               cur_addr, rd_addr;
  logic signed [CURSOR_W-1:0]  cur_inc, cur_step;

  asl_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (NUM_PIXELS)
  ) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_strip   = !cursor_r[CURSOR_W-1] &&
                      (cursor_r[CURSOR_W-2:0] < (CURSOR_W-1)'(NUM_PIXELS));
  assign cur_addr   = cursor_r[AW-1:0];
  assign sweep_last = (sweep_r == AW'(NUM_PIXELS - 1));
  assign rd_ok      = (32'(item_r.read_index) < 32'(NUM_PIXELS));
  assign rd_addr    = AW'(item_r.read_index);

  // The cursor stops at its maximum; only landing exactly on the strip end wraps.
  assign cur_inc  = (cursor_r != CURSOR_MAX) ? cursor_r + 18'sd1 : cursor_r;
  assign cur_step = (item_r.wrap && (cur_inc == CURSOR_W'(NUM_PIXELS))) ? '0 : cur_inc;

  assign step_cursor = ((state_r == ST_DRAW) && !in_strip) || (state_r == ST_DRAW_WR);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          unique case (q_entry.func)
            FUNC_DRAW: state_nxt = (q_entry.reps != 8'd0) ? ST_DRAW : ST_IDLE;
            FUNC_FILL: state_nxt = ST_FILL;
            FUNC_READ: state_nxt = ST_READ;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        if (in_strip) begin
          state_nxt = ST_DRAW_WR;
        end else if (pass_r == 8'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAW_WR: begin
        state_nxt = (pass_r == 8'd1) ? ST_IDLE : ST_DRAW;
      end
      ST_READ: begin
        if (!out_valid_r) state_nxt = ST_READ_DATA;
      end
      ST_READ_DATA: begin
        state_nxt = ST_IDLE;
      end
      ST_FILL: begin
        if (sweep_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = sweep_r;
    ram_raddr = cur_addr;
    ram_wdata = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        q_pop = !q_stat.empty;
      end
      ST_DRAW: begin
        ram_re = in_strip;
      end
      ST_DRAW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = {sat_add(ram_rdata[23:16], item_r.red),
                     sat_add(ram_rdata[15:8],  item_r.green),
                     sat_add(ram_rdata[7:0],   item_r.blue)};
      end
      ST_READ: begin
        ram_re    = !out_valid_r;
        ram_raddr = rd_addr;
      end
      ST_READ_DATA: begin
        out_load = 1'b1;
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {3{item_r.fill_level}};
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Datapath registers.
  always_comb begin
    item_nxt   = q_pop ? q_entry : item_r;
    cursor_nxt = cursor_r;
    pass_nxt   = pass_r;
    sweep_nxt  = sweep_r;
    if (q_pop) begin
      pass_nxt = q_entry.reps;
      if ((q_entry.func == FUNC_DRAW) && q_entry.first) begin
        cursor_nxt = q_entry.load;
      end
    end
    if (step_cursor) begin
      cursor_nxt = cur_step;
      pass_nxt   = pass_r - 8'd1;
    end
    if ((state_r == ST_CLEAR) || (state_r == ST_FILL)) begin
      sweep_nxt = sweep_last ? '0 : sweep_r + AW'(1);
    end
    out_pix_nxt   = out_load ? (rd_ok ? ram_rdata : '0) : out_pix_r;
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cursor_r    <= '0;
      pass_r      <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      pass_r      <= pass_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_pix_r <= out_pix_nxt;
  end

  assign bk_stat.init_busy = (state_r == ST_CLEAR);
  assign out_valid         = out_valid_r;
  assign out_read_red      = out_pix_r[23:16];
  assign out_read_green    = out_pix_r[15:8];
  assign out_read_blue     = out_pix_r[7:0];

`ifndef SYNTHESIS
  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW_WR) |-> ($past(state_r) == ST_DRAW))
    else $error("draw write without a preceding read");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_READ_DATA))
    else $error("result raised outside a read");

  a_pass_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAW) || (state_r == ST_DRAW_WR)) |-> (pass_r != 8'd0))
    else $error("draw pass with zero count left");
`endif

endmodule

// ===== hdl/additive_sprite_line_compositor_core.sv =====
// Top level of the additive sprite line compositor.
`timescale 1ns / 1ps

// Additive sprite compositor for a one-dimensional RGB strip of NUM_PIXELS
// pixels. Input words are draw (func 0), fill (func 1) or read (func 2); func 3
// is accepted and dropped. The front stage classifies each word, applies the
// brightness shift to the sprite color and, for the first pixel of a sprite,
// computes the cursor as floor((position + spread_step * 2^(16 - shift)) / 2^16)
// at full width. Words then wait in a four-deep queue for the back sequencer,
// which owns the single frame store memory (one write and one registered read
// per cycle). Steps per word in the back: the word is dequeued, then a draw
// reads and then saturating-writes each covered pixel that lies on the strip
// and only steps the cursor past covered pixels off the strip; a fill writes
// every pixel in turn; a read issues the address, then loads the data into
// the output register, valid in the cycle after, and also waits while an
// earlier result has not been taken. After reset the block runs a clearing
// pass over every pixel that zeroes the store, during which no input word
// is accepted; configuration writes are taken at any time and cfg_ready stays
// high. The brightness register is sampled when a word is accepted, so it
// should only be written while the block is idle. Results leave from an
// output register, so the back keeps working on draws and fills while a read
// result waits.
module additive_sprite_line_compositor_core #(
  parameter int NUM_PIXELS = asl_pkg::NUM_PIXELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic                 in_first_pixel,
  input  logic signed [31:0]   in_sprite_position,
  input  logic signed [15:0]   in_spread_step,
  input  logic [7:0]           in_repeat_count,
  input  logic                 in_wrap_enable,
  input  logic [7:0]           in_sprite_red,
  input  logic [7:0]           in_sprite_green,
  input  logic [7:0]           in_sprite_blue,
  input  logic [7:0]           in_read_index,
  input  logic [7:0]           in_fill_level,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_read_red,
  output logic [7:0]           out_read_green,
  output logic [7:0]           out_read_blue,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_brightness_shift
);
  import asl_pkg::*;

  entry_t   push_entry, pop_entry;
  logic     push, pop;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  // The brightness register can always take a write.
  assign cfg_ready = 1'b1;

  asl_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_first_pixel       (in_first_pixel),
    .in_sprite_position   (in_sprite_position),
    .in_spread_step       (in_spread_step),
    .in_repeat_count      (in_repeat_count),
    .in_wrap_enable       (in_wrap_enable),
    .in_sprite_red        (in_sprite_red),
    .in_sprite_green      (in_sprite_green),
    .in_sprite_blue       (in_sprite_blue),
    .in_read_index        (in_read_index),
    .in_fill_level        (in_fill_level),
    .cfg_valid            (cfg_valid),
    .cfg_brightness_shift (cfg_brightness_shift),
    .q_stat               (q_stat),
    .bk_stat              (bk_stat),
    .push                 (push),
    .entry                (push_entry)
  );

  // Queue between the two halves; each side stalls on its own.
  asl_queue #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .stat      (q_stat)
  );

  asl_back #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_entry        (pop_entry),
    .q_stat         (q_stat),
    .q_pop          (pop),
    .bk_stat        (bk_stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_red   (out_read_red),
    .out_read_green (out_read_green),
    .out_read_blue  (out_read_blue)
  );

endmodule

// ===== tb/sv/additive_sprite_line_compositor_core_tb.sv =====
// Self-checking testbench for the additive sprite line compositor core.
`timescale 1ns / 1ps

module additive_sprite_line_compositor_core_tb;
  import asl_pkg::*;

  localparam int NUM_PIX = NUM_PIXELS_DEFAULT;
  // Worst case the block can still be busy once the last read result is out:
  // a full queue plus the word in work, each a draw of 255 on-strip pixels,
  // with one more such draw and a fill on top as margin.
  localparam int SETTLE_CYCLES = (QUEUE_DEPTH + 2) * 511 + NUM_PIX;
  // Cycles in a row with no word moving on any channel before giving up.
  localparam int QUIET_LIMIT = 20000;
  // Length of the one long result stall.
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 130;

  // One input word, field for field as the ports carry it.
  typedef struct packed {
    logic [1:0]          func;
    logic                first;
    logic signed [31:0]  position;
    logic signed [15:0]  spread;
    logic [7:0]          reps;
    logic                wrap;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          read_index;
    logic [7:0]          fill_level;
  } sprite_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Shadow copy of the strip. Every accepted word is applied to it in order,
  // and each read word leaves the pixel it should return in a queue that the
  // result side drains.
  class strip_shadow;
    rgb_t        strip [NUM_PIX];
    int          cursor;
    int unsigned shift;
    rgb_t        pending_pixels [$];
    int          errors;

    function new();
      foreach (strip[i]) strip[i] = '0;
      cursor = 0;
      shift  = 0;
      errors = 0;
    endfunction

    function void set_shift(input logic [2:0] v);
      shift = v;
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction

    function logic [7:0] brighten(input logic [7:0] old_v, input logic [7:0] add_v);
      int total;
      total = old_v + add_v;
      return (total > 255) ? 8'd255 : 8'(total);
    endfunction

    function void accept_word(input sprite_word_t w);
      logic [7:0] add_r, add_g, add_b;
      longint     offset;
      case (w.func)
        FUNC_DRAW: begin
          add_r = w.red >> shift;
          add_g = w.green >> shift;
          add_b = w.blue >> shift;
          if (w.first) begin
            // One spread step is 2^(16 - shift) in 16.16 units, summed at full
            // width; the arithmetic shift gives the floor of the division.
            offset = longint'(w.position)
                     + longint'(w.spread) * (longint'(1) << (16 - shift));
            cursor = int'(offset >>> 16);
          end
          repeat (w.reps) begin
            if (cursor >= 0 && cursor < NUM_PIX) begin
              strip[cursor].red   = brighten(strip[cursor].red, add_r);
              strip[cursor].green = brighten(strip[cursor].green, add_g);
              strip[cursor].blue  = brighten(strip[cursor].blue, add_b);
            end
            if (cursor < CURSOR_MAX) cursor++;
            if (cursor == NUM_PIX && w.wrap) cursor = 0;
          end
        end
        FUNC_FILL: begin
          foreach (strip[i]) strip[i] = {3{w.fill_level}};
        end
        FUNC_READ: begin
          if (w.read_index < NUM_PIX) pending_pixels.push_back(strip[w.read_index]);
          else pending_pixels.push_back('0);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_channel(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void compare_pixel(input rgb_t got);
      rgb_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: result word with no read waiting, expected none, got %0d/%0d/%0d",
                 $time, got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      check_channel("read_red", want.red, got.red);
      check_channel("read_green", want.green, got.green);
      check_channel("read_blue", want.blue, got.blue);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          in_func = FUNC_DRAW;
  logic                in_first_pixel = 1'b0;
  logic signed [31:0]  in_sprite_position = '0;
  logic signed [15:0]  in_spread_step = '0;
  logic [7:0]          in_repeat_count = '0;
  logic                in_wrap_enable = 1'b0;
  logic [7:0]          in_sprite_red = '0;
  logic [7:0]          in_sprite_green = '0;
  logic [7:0]          in_sprite_blue = '0;
  logic [7:0]          in_read_index = '0;
  logic [7:0]          in_fill_level = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          out_read_red;
  logic [7:0]          out_read_green;
  logic [7:0]          out_read_blue;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_brightness_shift = '0;

  // Set by the stimulus for a stretch where neither side inserts gaps.
  logic no_idle = 1'b0;
  // Each increment asks the result side for one long stall.
  int   hold_requests = 0;

  strip_shadow sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  additive_sprite_line_compositor_core #(
    .NUM_PIXELS(NUM_PIX)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_first_pixel      (in_first_pixel),
    .in_sprite_position  (in_sprite_position),
    .in_spread_step      (in_spread_step),
    .in_repeat_count     (in_repeat_count),
    .in_wrap_enable      (in_wrap_enable),
    .in_sprite_red       (in_sprite_red),
    .in_sprite_green     (in_sprite_green),
    .in_sprite_blue      (in_sprite_blue),
    .in_read_index       (in_read_index),
    .in_fill_level       (in_fill_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_read_red        (out_read_red),
    .out_read_green      (out_read_green),
    .out_read_blue       (out_read_blue),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_brightness_shift(cfg_brightness_shift)
  );

  // A word with every field random, func code 3 included. The builders below
  // start from one of these, so fields that a word does not use still toggle.
  function automatic sprite_word_t junk_word();
    logic [127:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(sprite_word_t)-1:0];
  endfunction

  function automatic sprite_word_t make_draw(input logic first, input logic [31:0] pos,
                                             input logic [15:0] spread, input logic [7:0] reps,
                                             input logic wrap, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    sprite_word_t w;
    w = junk_word();
    w.func     = FUNC_DRAW;
    w.first    = first;
    w.position = pos;
    w.spread   = spread;
    w.reps     = reps;
    w.wrap     = wrap;
    w.red      = r;
    w.green    = g;
    w.blue     = b;
    return w;
  endfunction

  function automatic sprite_word_t make_read(input logic [7:0] idx);
    sprite_word_t w;
    w = junk_word();
    w.func       = FUNC_READ;
    w.read_index = idx;
    return w;
  endfunction

  function automatic sprite_word_t make_fill(input logic [7:0] level);
    sprite_word_t w;
    w = junk_word();
    w.func       = FUNC_FILL;
    w.fill_level = level;
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid is left
  // high so that back-to-back words need no second assignment in one step;
  // it only drops for a random gap or when the stimulus settles the block.
  task automatic send_word(input sprite_word_t w);
    if (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 26);
    end
    in_valid           <= 1'b1;
    in_func            <= w.func;
    in_first_pixel     <= w.first;
    in_sprite_position <= w.position;
    in_spread_step     <= w.spread;
    in_repeat_count    <= w.reps;
    in_wrap_enable     <= w.wrap;
    in_sprite_red      <= w.red;
    in_sprite_green    <= w.green;
    in_sprite_blue     <= w.blue;
    in_read_index      <= w.read_index;
    in_fill_level      <= w.fill_level;
    do @(posedge clk); while (!in_ready);
    sb.accept_word(w);
  endtask

  task automatic write_shift(input logic [2:0] v);
    cfg_valid            <= 1'b1;
    cfg_brightness_shift <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_shift(v);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering words, waits for every read result, then gives the block
  // time to finish draws and fills that produce no result.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly sprites: a first pixel with a position near the strip followed by
  // a run of continuation pixels. Reads lean toward where the latest sprite
  // landed. A few words are pure noise, and a few continuation pixels reload
  // the cursor from a random position. Fills are rare since each walks the
  // whole strip; most repeat counts are small.
  task automatic random_phase(input int count);
    sprite_word_t w;
    int           pick;
    int           sprite_left;
    int           base_pixel;
    sprite_left = 0;
    base_pixel  = 0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        w = junk_word();
      end else if (pick < 6) begin
        w = make_fill(8'($urandom()));
      end else if (pick < 23) begin
        w = make_read(8'(base_pixel + $urandom_range(0, 15)));
      end else if (pick < 40) begin
        w = make_read(8'($urandom()));
      end else begin
        w = junk_word();
        w.func = FUNC_DRAW;
        if (sprite_left == 0 || $urandom_range(99) < 5) begin
          sprite_left = $urandom_range(1, 12);
          base_pixel  = $urandom_range(0, 300) - 20;
          w.first     = 1'b1;
          w.position  = base_pixel * 65536 + $urandom_range(0, 65535);
          if ($urandom_range(99) < 70) w.spread = 16'($urandom_range(0, 16) - 8);
        end else begin
          sprite_left--;
          w.first = ($urandom_range(99) < 3);
        end
        w.reps = ($urandom_range(99) < 90) ? 8'($urandom_range(0, 6))
                                           : 8'($urandom_range(0, 255));
      end
      send_word(w);
    end
  endtask

  initial begin : stimulus
    int phase_shift [8];
    phase_shift = '{3'd7, 3'd3, 3'd0, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_shift(3'd0);

    // Directed part at unit brightness. The strip is all zero after reset.
    send_word(make_read(8'd0));
    send_word(make_read(8'd255));
    send_word(make_draw(1'b1, 32'd0, 16'd0, 8'd3, 1'b0, 8'd255, 8'd1, 8'd128));
    send_word(make_read(8'd1));
    // A zero repeat count draws nothing and must leave the cursor at 3.
    send_word(make_draw(1'b0, 32'd0, 16'd0, 8'd0, 1'b0, 8'd9, 8'd9, 8'd9));
    send_word(make_draw(1'b0, 32'd0, 16'd0, 8'd1, 1'b0, 8'd0, 8'd255, 8'd0));
    send_word(make_read(8'd3));
    // Adding onto pixel 0 saturates red and blue.
    send_word(make_draw(1'b1, 32'd0, 16'd0, 8'd1, 1'b0, 8'd200, 8'd200, 8'd200));
    send_word(make_read(8'd0));
    // Starting three pixels left of the strip: the first three passes are skipped.
    send_word(make_draw(1'b1, 32'hFFFD_0000, 16'd0, 8'd5, 1'b0, 8'd10, 8'd20, 8'd30));
    send_word(make_read(8'd1));
    // Run over the strip end with wrap set: 254, 255, then 0 and 1.
    send_word(make_draw(1'b1, 32'h00FE_0000, 16'd0, 8'd4, 1'b1, 8'd5, 8'd6, 8'd7));
    send_word(make_read(8'd255));
    // A cursor already past the end never wraps.
    send_word(make_draw(1'b1, 32'h012C_0000, 16'd0, 8'd255, 1'b1, 8'd40, 8'd40, 8'd40));
    send_word(make_draw(1'b0, 32'd0, 16'd0, 8'd2, 1'b1, 8'd40, 8'd40, 8'd40));
    send_word(make_read(8'd44));
    // Position 5.5 pixels, one spread step back: floor lands on pixel 4.
    send_word(make_draw(1'b1, 32'h0005_8000, 16'hFFFF, 8'd1, 1'b0, 8'd1, 8'd2, 8'd3));
    send_word(make_read(8'd4));
    send_word(make_draw(1'b1, 32'h000A_0000, 16'd2, 8'd1, 1'b0, 8'd77, 8'd88, 8'd99));
    send_word(make_read(8'd12));
    // Extremes of position and spread, both far off the strip.
    send_word(make_draw(1'b1, 32'h7FFF_FFFF, 16'h7FFF, 8'd1, 1'b0, 8'd1, 8'd1, 8'd1));
    send_word(make_draw(1'b1, 32'h8000_0000, 16'h8000, 8'd1, 1'b0, 8'd1, 8'd1, 8'd1));
    begin : unused_code
      sprite_word_t w;
      w = junk_word();
      w.func = FUNC_UNUSED;
      send_word(w);
    end
    send_word(make_fill(8'h3C));
    send_word(make_read(8'd200));
    send_word(make_read(8'd0));
    settle_block();

    // Push the cursor from its highest load value up to its ceiling with
    // long off-strip runs, then make sure nothing on the strip changed.
    send_word(make_draw(1'b1, 32'h7FFF_FFFF, 16'h7FFF, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255));
    repeat (262) begin
      send_word(make_draw(1'b0, 32'd0, 16'd0, 8'd255, 1'b1, 8'd255, 8'd255, 8'd255));
    end
    send_word(make_draw(1'b0, 32'd0, 16'd0, 8'd3, 1'b1, 8'd255, 8'd255, 8'd255));
    send_word(make_read(8'd0));
    send_word(make_read(8'd255));
    settle_block();

    // Random traffic under each brightness setting. One phase runs with no
    // gaps on either side; another starts with a long result stall while
    // reads keep coming, so the queue fills and the input backs up.
    for (int p = 0; p < 8; p++) begin
      write_shift(3'(phase_shift[p]));
      no_idle <= (p == 3);
      if (p == 5) begin
        hold_requests <= hold_requests + 1;
        repeat (30) send_word(make_read(8'($urandom())));
      end
      random_phase(PHASE_WORDS);
      settle_block();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("additive_sprite_line_compositor_core regression: pass");
    end else begin
      $display("additive_sprite_line_compositor_core regression: fail");
    end
    $finish;
  end

  // Result side: checks every accepted result word and drives out_ready,
  // with random back-pressure and the long stalls that the stimulus asks for.
  initial begin : result_sink
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) sb.compare_pixel({out_read_red, out_read_green, out_read_blue});
      if (hold_left == 0 && holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 26);
      end
    end
  end

  // Ends a hung run: counts cycles in which no word moves on any channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("additive_sprite_line_compositor_core regression: fail");
    $finish;
  end

endmodule
